>>> src/fsa_pkg.sv
package fsa_pkg;

   // Default pool size
   localparam int DEF_SLOT_COUNT = 512;

   // Field widths of the stream words
   localparam int OP_W        = 2;
   localparam int SLOT_IDX_W  = 9;
   localparam int USED_CNT_W  = 10;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 24;

   // Operation codes
   typedef enum logic [OP_W-1:0] {
      OP_CLEAR   = 2'd0,
      OP_ALLOC   = 2'd1,
      OP_RELEASE = 2'd2
   } op_type;

   // Control sequence: take a word and read, then modify and write back
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

endpackage

>>> src/free_list_slot_allocator_core.sv
// A result word is registered in the write-back step that follows acceptance
// of its request word. No new request word is taken until that step is done:
// the head's link is read on acceptance and written back in that step.
// A waiting result word stalls only the write-back of the next request word.
// Reset (synchronous, active high) empties the pool at once: a fill count marks
// untouched slots, which read as linked to the next slot and unoccupied.
module free_list_slot_allocator_core #(
   parameter int SLOT_COUNT = fsa_pkg::DEF_SLOT_COUNT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [1:0] operation, [10:2] slot_index, [11] text_nonempty, [15:12] zero
   input  logic [fsa_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [8:0] granted_slot, [9] success, [19:10] used_count, [23:20] zero
   output logic [fsa_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int AW = $clog2(SLOT_COUNT);
   localparam int LW = $clog2(SLOT_COUNT + 1);

   // Link memory: each word holds {link, occupied}
   logic [LW:0]              mem [SLOT_COUNT];
   logic [LW:0]              rd_data_ff;

   fsa_pkg::state_type       state_ff, state_in;
   logic [LW-1:0]            head_ff, head_in;
   logic [LW-1:0]            count_ff, count_in;
   logic [LW-1:0]            fill_ff, fill_in;

   fsa_pkg::op_type          op_ff;
   logic [AW-1:0]            addr_ff;
   logic                     idx_ok_ff;
   logic                     text_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [fsa_pkg::SLOT_IDX_W-1:0] rsp_slot_ff;
   logic                     rsp_ok_ff;
   logic [fsa_pkg::USED_CNT_W-1:0] rsp_count_ff;

   logic                     out_free;
   logic                     accept;
   logic                     rd_en;
   logic                     done;
   logic [AW-1:0]            rd_addr;
   fsa_pkg::op_type          req_op;
   logic [fsa_pkg::SLOT_IDX_W-1:0] req_idx;

   logic                     entry_live;
   logic [LW-1:0]            link_eff;
   logic                     mark_eff;
   logic                     alloc_ok;
   logic                     release_ok;
   logic                     wr_en;
   logic [LW:0]              wr_data;
   logic [fsa_pkg::SLOT_IDX_W-1:0] slot_out;
   logic                     ok_out;

   // Unpack request word
   assign req_op  = fsa_pkg::op_type'(req_tdata[1:0]);
   assign req_idx = req_tdata[10:2];

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign accept   = req_tvalid && req_tready;
   assign done     = (state_ff == fsa_pkg::ST_EXEC) && out_free;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fsa_pkg::ST_IDLE: if (req_tvalid) state_in = fsa_pkg::ST_EXEC;
         fsa_pkg::ST_EXEC: if (out_free) state_in = fsa_pkg::ST_IDLE;
         default:          state_in = fsa_pkg::ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      unique case (state_ff)
         fsa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            rd_en      = req_tvalid;
         end
         fsa_pkg::ST_EXEC: begin
            req_tready = 1'b0;
            rd_en      = 1'b0;
         end
         default: begin
            req_tready = 1'b0;
            rd_en      = 1'b0;
         end
      endcase
   end

   // Read the head's link for allocate, the named slot otherwise
   always_comb begin
      if (req_op == fsa_pkg::OP_ALLOC) begin
         rd_addr = AW'(head_ff);
      end else begin
         rd_addr = AW'(req_idx);
      end
   end

   // Slots at or above the fill count were never touched since clear
   assign entry_live = LW'(addr_ff) < fill_ff;
   assign link_eff   = entry_live ? rd_data_ff[LW:1] : LW'(addr_ff) + LW'(1);
   assign mark_eff   = entry_live ? rd_data_ff[0] : 1'b0;

   assign alloc_ok   = (op_ff == fsa_pkg::OP_ALLOC)
                       && (32'(count_ff) < 32'(SLOT_COUNT))
                       && (32'(head_ff) < 32'(SLOT_COUNT));
   assign release_ok = (op_ff == fsa_pkg::OP_RELEASE) && idx_ok_ff && mark_eff
                       && (count_ff != '0);

   // Modify: next head, count, fill count and write-back word
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      fill_in  = fill_ff;
      wr_en    = 1'b0;
      wr_data  = {link_eff, 1'b0};
      slot_out = '0;
      ok_out   = 1'b0;
      case (op_ff)
         fsa_pkg::OP_CLEAR: begin
            head_in  = '0;
            count_in = '0;
            fill_in  = '0;
            ok_out   = 1'b1;
         end
         fsa_pkg::OP_ALLOC: begin
            if (alloc_ok) begin
               head_in  = link_eff;
               count_in = count_ff + LW'(1);
               if (!entry_live) fill_in = fill_ff + LW'(1);
               wr_en    = 1'b1;
               wr_data  = {link_eff, text_ff};
               slot_out = fsa_pkg::SLOT_IDX_W'(head_ff);
               ok_out   = 1'b1;
            end
         end
         fsa_pkg::OP_RELEASE: begin
            if (release_ok) begin
               head_in  = LW'(addr_ff);
               count_in = count_ff - LW'(1);
               wr_en    = 1'b1;
               wr_data  = {head_ff, 1'b0};
               ok_out   = 1'b1;
            end
         end
         default: begin
            ok_out = 1'b0;
         end
      endcase
   end

   // Link memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (done && wr_en) mem[addr_ff] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   // Hold the accepted word
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_op;
         addr_ff   <= rd_addr;
         idx_ok_ff <= 32'(req_idx) < 32'(SLOT_COUNT);
         text_ff   <= req_tdata[11];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fsa_pkg::ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (done) begin
            head_ff  <= head_in;
            count_ff <= count_in;
            fill_ff  <= fill_in;
         end
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_slot_ff  <= slot_out;
         rsp_ok_ff    <= ok_out;
         rsp_count_ff <= fsa_pkg::USED_CNT_W'(count_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_count_ff, rsp_ok_ff, rsp_slot_ff};

   // Count stays within the pool
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(SLOT_COUNT))
      else $error("slot count exceeds pool size");

   // Fill count stays within the pool
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= 32'(SLOT_COUNT))
      else $error("fill count exceeds pool size");

   // An accepted word moves to the write-back step next cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == fsa_pkg::ST_EXEC)
      else $error("accepted word not executed");

   // Write-back always produces a result word
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_valid_ff)
      else $error("write-back without result");

   // No read is issued while a word is in write-back
   a_no_read_exec: assert property (@(posedge clock) disable iff (reset)
      state_ff == fsa_pkg::ST_EXEC |-> !rd_en && !req_tready)
      else $error("read issued during write-back");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int SLOTS = fsa_pkg::DEF_SLOT_COUNT;
   localparam int OP_W = fsa_pkg::OP_W;
   localparam int SLOT_IDX_W = fsa_pkg::SLOT_IDX_W;
   localparam int USED_CNT_W = fsa_pkg::USED_CNT_W;
   localparam int REQ_DATA_W = fsa_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = fsa_pkg::RSP_DATA_W;
   // operation code with no meaning to the block
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   // two copies of the pool: one shadows the stimulus, one checks results
   localparam int GEN = 0;
   localparam int CHK = 1;
   localparam int QUIET_LIMIT = 5000;
   localparam int LONG_HOLD = 200;
   localparam int DRAIN_CYCLES = 10;
   localparam int RANDOM_ITEMS = 120;
   localparam int ALLOC_BURST = 60;

   typedef struct packed {
      logic [3:0]            pad;
      logic                  text_nonempty;
      logic [SLOT_IDX_W-1:0] slot_index;
      logic [OP_W-1:0]       operation;
   } alloc_req_type;

   typedef struct packed {
      logic [3:0]            pad;
      logic [USED_CNT_W-1:0] used_count;
      logic                  success;
      logic [SLOT_IDX_W-1:0] granted_slot;
   } alloc_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [1:0] operation, [10:2] slot_index, [11] text_nonempty, [15:12] zero
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [8:0] granted_slot, [9] success, [19:10] used_count, [23:20] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // pool state, one copy per user
   logic [USED_CNT_W-1:0] link_tbl [2][SLOTS];
   bit                    occupied [2][SLOTS];
   logic [USED_CNT_W-1:0] head_ptr [2];
   logic [USED_CNT_W-1:0] used_cnt [2];

   alloc_req_type pending_reqs [$];
   alloc_rsp_type expected_rsps [$];
   alloc_rsp_type got_rsp;
   alloc_rsp_type want_rsp;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;
   int quiet_cycles = 0;
   int hold_left = 0;
   bit hold_armed = 1'b0;
   bit hold_done = 1'b0;

   free_list_slot_allocator_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // empty the pool: every slot links to the next one
   function automatic void clear_pool(input int m);
      for (int i = 0; i < SLOTS; i++) begin
         link_tbl[m][i] = USED_CNT_W'(i + 1);
         occupied[m][i] = 1'b0;
      end
      head_ptr[m] = '0;
      used_cnt[m] = '0;
   endfunction

   // apply one operation to a pool copy and return the result word it yields
   function automatic alloc_rsp_type apply_op(input int m, input alloc_req_type r);
      alloc_rsp_type s;
      int slot;
      s = '0;
      case (r.operation)
         fsa_pkg::OP_CLEAR: begin
            clear_pool(m);
            s.success = 1'b1;
         end
         fsa_pkg::OP_ALLOC: begin
            if (used_cnt[m] < SLOTS && head_ptr[m] < SLOTS) begin
               slot = int'(head_ptr[m]);
               head_ptr[m] = link_tbl[m][slot];
               used_cnt[m] = used_cnt[m] + 1'b1;
               occupied[m][slot] = r.text_nonempty;
               s.granted_slot = SLOT_IDX_W'(slot);
               s.success = 1'b1;
            end
         end
         fsa_pkg::OP_RELEASE: begin
            if (occupied[m][r.slot_index] && used_cnt[m] != 0) begin
               used_cnt[m] = used_cnt[m] - 1'b1;
               occupied[m][r.slot_index] = 1'b0;
               link_tbl[m][r.slot_index] = head_ptr[m];
               head_ptr[m] = USED_CNT_W'(r.slot_index);
               s.success = 1'b1;
            end
         end
         default: ;
      endcase
      s.used_count = used_cnt[m];
      return s;
   endfunction

   function automatic void flag_error(input string msg);
      error_count++;
      if (error_count <= 10)
         $display("mismatch at %0t: %s", $realtime, msg);
   endfunction

   // queue a request word and advance the stimulus shadow of the pool
   function automatic void queue_op(input logic [OP_W-1:0] op,
                                    input logic [SLOT_IDX_W-1:0] idx,
                                    input logic text);
      alloc_req_type r;
      r = '0;
      r.operation = op;
      r.slot_index = idx;
      r.text_nonempty = text;
      void'(apply_op(GEN, r));
      pending_reqs.push_back(r);
   endfunction

   // find an occupied slot from a random start, or fall back to the start
   function automatic logic [SLOT_IDX_W-1:0] pick_occupied();
      int start;
      int k;
      start = $urandom_range(0, SLOTS - 1);
      for (int i = 0; i < SLOTS; i++) begin
         k = (start + i) % SLOTS;
         if (occupied[GEN][k])
            return SLOT_IDX_W'(k);
      end
      return SLOT_IDX_W'(start);
   endfunction

   function automatic void queue_random();
      int roll;
      logic [SLOT_IDX_W-1:0] idx;
      logic text;
      roll = $urandom_range(0, 99);
      idx = SLOT_IDX_W'($urandom_range(0, SLOTS - 1));
      text = 1'($urandom_range(0, 1));
      if (roll < 3)
         queue_op(fsa_pkg::OP_CLEAR, idx, text);
      else if (roll < 6)
         queue_op(OP_UNUSED, idx, text);
      else if (roll < 52)
         queue_op(fsa_pkg::OP_ALLOC, idx, $urandom_range(0, 3) != 0);
      else if (roll < 90)
         queue_op(fsa_pkg::OP_RELEASE, pick_occupied(), text);
      else
         queue_op(fsa_pkg::OP_RELEASE, idx, text);
   endfunction

   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0);
   endtask

   // offer request words, idling at random between them
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_reqs.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // accept result words; hold off once for a long stretch when armed
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_armed && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end else begin
         rsp_tready <= $urandom_range(0, 99) >= recv_idle_pct;
      end
   end

   // predict on each accepted request word, check each accepted result word
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_rsps.push_back(apply_op(CHK, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got_rsp = rsp_tdata;
            if (expected_rsps.size() == 0) begin
               flag_error($sformatf("result word %h with none expected", rsp_tdata));
            end else begin
               want_rsp = expected_rsps.pop_front();
               if (got_rsp.granted_slot !== want_rsp.granted_slot ||
                   got_rsp.success !== want_rsp.success ||
                   got_rsp.used_count !== want_rsp.used_count)
                  flag_error($sformatf(
                     "granted_slot %0d/%0d success %0b/%0b used_count %0d/%0d (exp/got)",
                     want_rsp.granted_slot, got_rsp.granted_slot,
                     want_rsp.success, got_rsp.success,
                     want_rsp.used_count, got_rsp.used_count));
            end
         end
      end
   end

   // end the run when no word moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      clear_pool(GEN);
      clear_pool(CHK);
      send_idle_pct = 34;
      recv_idle_pct = 64;

      // directed: unknown code, empty pool, LIFO reuse, empty text, clear
      queue_op(OP_UNUSED, '1, 1'b1);
      queue_op(fsa_pkg::OP_RELEASE, '0, 1'b0);
      queue_op(fsa_pkg::OP_ALLOC, '1, 1'b1);
      queue_op(fsa_pkg::OP_ALLOC, '0, 1'b0);
      queue_op(fsa_pkg::OP_ALLOC, '0, 1'b1);
      queue_op(fsa_pkg::OP_RELEASE, 9'd1, 1'b0);
      queue_op(fsa_pkg::OP_RELEASE, 9'd0, 1'b1);
      queue_op(fsa_pkg::OP_RELEASE, 9'd0, 1'b0);
      queue_op(fsa_pkg::OP_ALLOC, '0, 1'b1);
      queue_op(fsa_pkg::OP_RELEASE, '1, 1'b1);
      queue_op(fsa_pkg::OP_RELEASE, 9'd2, 1'b0);
      queue_op(fsa_pkg::OP_RELEASE, 9'd0, 1'b0);
      queue_op(fsa_pkg::OP_ALLOC, '1, 1'b1);
      queue_op(fsa_pkg::OP_ALLOC, '0, 1'b1);
      queue_op(OP_UNUSED, '0, 1'b0);
      queue_op(fsa_pkg::OP_CLEAR, '1, 1'b1);
      queue_op(fsa_pkg::OP_RELEASE, 9'd2, 1'b1);
      queue_op(fsa_pkg::OP_ALLOC, '0, 1'b1);
      queue_op(fsa_pkg::OP_CLEAR, '0, 1'b0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         @(negedge clock);
         case (phase)
            0: begin
               send_idle_pct = 34;
               recv_idle_pct = 64;
            end
            1: begin
               send_idle_pct = 64;
               recv_idle_pct = 34;
               // allocate a burst, then free part of it
               repeat (ALLOC_BURST)
                  queue_op(fsa_pkg::OP_ALLOC,
                           SLOT_IDX_W'($urandom_range(0, SLOTS - 1)),
                           $urandom_range(0, 7) != 0);
               repeat (2) queue_op(OP_UNUSED, '0, 1'b1);
               repeat (10) queue_op(fsa_pkg::OP_RELEASE, pick_occupied(), 1'b0);
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               hold_armed = 1'b1;
            end
         endcase
         repeat (RANDOM_ITEMS) queue_random();
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

>>> sim.f
src/fsa_pkg.sv
src/free_list_slot_allocator_core.sv
tb/testbench.sv
